FILE: rtl/qled_pkg.sv
// Package for the quoted-literal escape decoder.
// Holds the status and terminator codes and the character constants.
// No dependencies.
`default_nettype none

package qled_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CodeW = 3;

  localparam logic [CodeW-1:0] ST_OK         = 3'd0;
  localparam logic [CodeW-1:0] ST_MISSING    = 3'd1;
  localparam logic [CodeW-1:0] ST_EMPTY      = 3'd2;
  localparam logic [CodeW-1:0] ST_BAD_ESCAPE = 3'd3;
  localparam logic [CodeW-1:0] ST_UNICODE    = 3'd4;
  localparam logic [CodeW-1:0] ST_TOO_MANY   = 3'd5;

  localparam logic [CodeW-1:0] TM_QUOTE   = 3'd0;
  localparam logic [CodeW-1:0] TM_BRACE   = 3'd1;
  localparam logic [CodeW-1:0] TM_NEWLINE = 3'd2;
  localparam logic [CodeW-1:0] TM_CR      = 3'd3;
  localparam logic [CodeW-1:0] TM_EOI     = 3'd4;

  localparam logic [CharW-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CharW-1:0] CH_CR        = 8'h0D;
  localparam logic [CharW-1:0] CH_TAB       = 8'h09;
  localparam logic [CharW-1:0] CH_NUL       = 8'h00;
  localparam logic [CharW-1:0] CH_BRACE     = 8'h7B;
  localparam logic [CharW-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CharW-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [CharW-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CharW-1:0] CH_LOWER_N   = 8'h6E;
  localparam logic [CharW-1:0] CH_LOWER_R   = 8'h72;
  localparam logic [CharW-1:0] CH_LOWER_T   = 8'h74;
  localparam logic [CharW-1:0] CH_DIGIT_0   = 8'h30;

  typedef struct packed {
    logic             is_empty;
    logic [CodeW-1:0] terminator;
    logic [CodeW-1:0] status;
    logic [CharW-1:0] out_char;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/quoted_literal_escape_decoder_unit.sv
// Quoted-literal escape decoder: decodes the body of a char or string literal.
// Uses qled_pkg for the status, terminator and character codes.
// An accepted request is held in the input register and moves to the result register once the output side can advance.
// Throughput: one request per cycle while the output side keeps taking results.
// Reset (rst, synchronous, active high) clears the literal state, the mode and both valids.
`default_nettype none

module quoted_literal_escape_decoder_unit
  import qled_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,     // literal_kind
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] source_byte
  input  wire logic        s_tuser,      // [0] end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,      // [7:0] out_char, [10:8] status,
                                         // [13:11] terminator, [14] is_empty
  output logic             m_tlast       // is_final
);

  logic             literal_kind;
  logic             in_valid;
  logic [CharW-1:0] in_byte;
  logic             in_eoi;

  logic             after_backslash;
  logic [1:0]       decoded_count;
  logic [CharW-1:0] held_char;
  logic [CodeW-1:0] first_error;
  logic             content_seen;

  logic             after_backslash_next;
  logic [1:0]       decoded_count_next;
  logic [CharW-1:0] held_char_next;
  logic [CodeW-1:0] first_error_next;
  logic             content_seen_next;

  result_t          res;
  logic             res_valid;
  logic             res_final;
  result_t          out_res;
  logic             adv;

  logic             fin_take;
  logic [CodeW-1:0] fin_term;
  logic             unit_take;
  logic [CharW-1:0] unit_val;
  logic [CodeW-1:0] unit_err;
  logic [CharW-1:0] quote;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign quote     = literal_kind ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    fin_take             = 1'b0;
    fin_term             = TM_QUOTE;
    unit_take            = 1'b0;
    unit_val             = CH_NUL;
    unit_err             = ST_OK;
    after_backslash_next = after_backslash;
    decoded_count_next   = decoded_count;
    held_char_next       = held_char;
    first_error_next     = first_error;
    content_seen_next    = content_seen;
    res                  = '0;
    res_valid            = 1'b0;
    res_final            = 1'b0;

    if (in_eoi) begin
      fin_take = 1'b1;
      fin_term = TM_EOI;
    end else if (in_byte == CH_NEWLINE) begin
      fin_take = 1'b1;
      fin_term = TM_NEWLINE;
    end else if (in_byte == CH_CR) begin
      fin_take = 1'b1;
      fin_term = TM_CR;
    end else if (after_backslash) begin
      after_backslash_next = 1'b0;
      unit_take            = 1'b1;
      if (literal_kind && in_byte == CH_BRACE) begin
        unit_val = CH_BRACE;
      end else if (in_byte == quote) begin
        unit_val = quote;
      end else begin
        case (in_byte)
          CH_BACKSLASH: unit_val = CH_BACKSLASH;
          CH_LOWER_N:   unit_val = CH_NEWLINE;
          CH_LOWER_R:   unit_val = CH_CR;
          CH_LOWER_T:   unit_val = CH_TAB;
          CH_DIGIT_0:   unit_val = CH_NUL;
          default:      unit_err = ST_BAD_ESCAPE;
        endcase
      end
    end else if (in_byte == quote) begin
      fin_take = 1'b1;
      fin_term = TM_QUOTE;
    end else if (literal_kind && in_byte == CH_BRACE) begin
      fin_take = 1'b1;
      fin_term = TM_BRACE;
    end else begin
      content_seen_next = 1'b1;
      if (in_byte[CharW-1]) begin
        unit_take = 1'b1;
        unit_err  = ST_UNICODE;
      end else if (in_byte == CH_BACKSLASH) begin
        after_backslash_next = 1'b1;
      end else begin
        unit_take = 1'b1;
        unit_val  = in_byte;
      end
    end

    if (fin_take) begin
      res_valid      = 1'b1;
      res_final      = 1'b1;
      res.terminator = fin_term;
      res.is_empty   = !content_seen;
      if (fin_term == TM_EOI || fin_term == TM_NEWLINE || fin_term == TM_CR) begin
        res.status = ST_MISSING;
      end else if (!literal_kind) begin
        if (!content_seen) begin
          res.status = ST_EMPTY;
        end else if (first_error != ST_OK) begin
          res.status = first_error;
        end else if (decoded_count > 2'd1) begin
          res.status = ST_TOO_MANY;
        end else begin
          res.status   = ST_OK;
          res.out_char = held_char;
        end
      end else begin
        res.status = first_error;
      end
      after_backslash_next = 1'b0;
      decoded_count_next   = 2'd0;
      held_char_next       = CH_NUL;
      first_error_next     = ST_OK;
      content_seen_next    = 1'b0;
    end else if (unit_take) begin
      if (decoded_count != 2'd2) begin
        decoded_count_next = decoded_count + 2'd1;
      end
      if (!literal_kind) begin
        if (decoded_count == 2'd0) begin
          held_char_next   = (unit_err != ST_OK) ? CH_NUL : unit_val;
          first_error_next = unit_err;
        end
      end else if (first_error == ST_OK) begin
        if (unit_err != ST_OK) begin
          first_error_next = unit_err;
        end else begin
          res_valid    = 1'b1;
          res.out_char = unit_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_kind    <= 1'b0;
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      after_backslash <= 1'b0;
      decoded_count   <= 2'd0;
      held_char       <= CH_NUL;
      first_error     <= ST_OK;
      content_seen    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        literal_kind <= cfg_data;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid        <= res_valid;
        after_backslash <= after_backslash_next;
        decoded_count   <= decoded_count_next;
        held_char       <= held_char_next;
        first_error     <= first_error_next;
        content_seen    <= content_seen_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tuser;
    end
    if (adv) begin
      out_res <= res;
      m_tlast <= res_final;
    end
  end

  assign m_tdata = {1'b0, out_res};

  // A string data byte carries zero status and terminator and only occurs in string mode.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (out_res.status == ST_OK && out_res.terminator == TM_QUOTE
                                && !out_res.is_empty && literal_kind))
    else $error("data result with nonzero status fields or in char mode");

  // Every final result leaves the literal state cleared.
  assert property (@(posedge clk) disable iff (rst)
    (adv && res_final) |=> (decoded_count == 2'd0 && !after_backslash && !content_seen
                             && first_error == ST_OK))
    else $error("literal state not cleared after final result");

  // A line end or end of input always reports a missing terminator.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && (out_res.terminator == TM_EOI || out_res.terminator == TM_NEWLINE
                             || out_res.terminator == TM_CR))
      |-> (out_res.status == ST_MISSING))
    else $error("unterminated literal without missing-terminator status");

endmodule

`default_nettype wire
